/* hdl/sha256_stream_hasher_defines.svh */
// assertion macros shared by the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SHA_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SHA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sha_pkg.sv */
// shared types and constants of the sha256 stream hasher
`timescale 1ns / 1ps

package sha_pkg;

    // byte source for one buffer write
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_MARK = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_TOP = 6'd63;
    localparam logic [2:0] MAX_BYTES = 3'd4;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       put;
        logic [1:0] byte_src;
        logic       comp_start;
        logic       round_en;
        logic       add_en;
        logic       restart;
        logic [2:0] out_idx;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } dp_status_t;

endpackage

/* hdl/sha256_stream_hasher.sv */
// top level of the streaming sha256 hasher
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"

// Streaming SHA-256 hasher.
// Input stream: s_axis_tdata carries up to four message bytes (first byte in
// bits 31..24) and a byte count in bits 34..32; s_axis_tlast marks the final
// transfer of a message. Counts above four are taken as four.
// Output stream: eight transfers per message, digest word in bits 31..0 and
// its index in bits 34..32, most significant word first; m_axis_tlast is set
// on the eighth word.
// Timing: an input transfer is taken in the idle state; its bytes are then
// written one per cycle. Each completed 64-byte block pauses the writing for
// the round unit (one round per cycle plus a final chaining add). The final
// transfer adds up to 72 padding bytes and one or two block runs, then
// the digest words appear, one per cycle while m_axis_tready is high.
// s_axis_tready is high only while the block is idle; one message item is
// processed at a time.
// Reset clears the counters and loads the initial hash value; the block is
// ready as soon as reset is released. A stalled receiver holds the current
// digest word and its index steady until it is taken.

module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero fill
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_axis_tlast
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_count  (s_axis_tdata[34:32]),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (word_index),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_word   (s_axis_tdata[31:0]),
        .status      (status),
        .digest_word (digest_word)
    );

    // output packing
    assign m_axis_tdata = {5'b00000, word_index, digest_word};

    // intake and digest output never overlap
    `SHA_ASSERT_SAME(a_no_overlap, clk, rst_n, s_axis_tready, !m_axis_tvalid, "ready during output")
    // the eighth word is the only one flagged last
    `SHA_ASSERT_SAME(a_last_index, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[34:32] == LAST_IDX, "last flag on wrong word")
    // digest words come out in index order
    `SHA_ASSERT_NEXT(a_index_step, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[34:32] == 3'($past(m_axis_tdata[34:32]) + 3'd1)), "digest index skipped")
    // after the final word the block is ready for the next message
    `SHA_ASSERT_NEXT(a_back_idle, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after digest")

endmodule

/* hdl/sha_dp.sv */
// sha256 datapath: byte window, schedule, round unit and hash words
`timescale 1ns / 1ps

module sha_dp
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [31:0] data_word,
    output dp_status_t  status,
    output logic [31:0] digest_word
);

    logic [31:0] data_reg;
    logic [31:0] win_reg [16];
    logic [31:0] work_reg [8];
    logic [31:0] hash_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] total_reg;
    logic [5:0]  round_reg;

    logic [7:0]  put_byte;
    logic [63:0] len_bits;
    logic [63:0] len_shift;
    logic [31:0] x15;
    logic [31:0] x2;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] w_cur;
    logic [31:0] a_w;
    logic [31:0] e_w;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] mj;
    logic [31:0] t1;
    logic [31:0] t2;

    // length field byte picked by the low bits of the fill
    always_comb
    begin
        len_bits  = {total_reg[60:0], 3'b000};
        len_shift = len_bits << {fill_reg[2:0], 3'b000};
    end

    // byte written into the block window
    always_comb
    begin
        case (cmd.byte_src)
            SRC_DATA: put_byte = data_reg[31:24];
            SRC_MARK: put_byte = PAD_MARK;
            SRC_ZERO: put_byte = 8'h00;
            default:  put_byte = len_shift[63:56];
        endcase
    end

    // message schedule word for this round
    always_comb
    begin
        x15 = win_reg[1];
        x2  = win_reg[14];
        s0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        s1  = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        if (round_reg[5:4] == 2'b00)
        begin
            w_cur = win_reg[0];
        end
        else
        begin
            w_cur = win_reg[0] + s0 + win_reg[9] + s1;
        end
    end

    // one compression round
    always_comb
    begin
        a_w    = work_reg[0];
        e_w    = work_reg[4];
        big_s1 = {e_w[5:0], e_w[31:6]} ^ {e_w[10:0], e_w[31:11]} ^ {e_w[24:0], e_w[31:25]};
        ch     = (e_w & work_reg[5]) ^ (~e_w & work_reg[6]);
        t1     = work_reg[7] + big_s1 + ch + ROUND_K[round_reg] + w_cur;
        big_s0 = {a_w[1:0], a_w[31:2]} ^ {a_w[12:0], a_w[31:13]} ^ {a_w[21:0], a_w[31:22]};
        mj     = (a_w & work_reg[1]) ^ (a_w & work_reg[2]) ^ (work_reg[1] & work_reg[2]);
        t2     = big_s0 + mj;
    end

    // item word, byte window and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg <= data_word;
        end
        else if (cmd.put && cmd.byte_src == SRC_DATA)
        begin
            data_reg <= {data_reg[23:0], 8'h00};
        end

        if (cmd.put)
        begin
            for (int j = 0; j < 15; j++)
            begin
                win_reg[j] <= {win_reg[j][23:0], win_reg[j + 1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], put_byte};
        end
        else if (cmd.round_en)
        begin
            for (int j = 0; j < 15; j++)
            begin
                win_reg[j] <= win_reg[j + 1];
            end
            win_reg[15] <= w_cur;
        end

        if (cmd.comp_start)
        begin
            for (int j = 0; j < 8; j++)
            begin
                work_reg[j] <= hash_reg[j];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // fill, byte total, round count and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            round_reg <= '0;
            for (int j = 0; j < 8; j++)
            begin
                hash_reg[j] <= INIT_H[j];
            end
        end
        else
        begin
            if (cmd.restart)
            begin
                fill_reg  <= '0;
                total_reg <= '0;
                for (int j = 0; j < 8; j++)
                begin
                    hash_reg[j] <= INIT_H[j];
                end
            end
            else
            begin
                if (cmd.put)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.put && cmd.byte_src == SRC_DATA)
                begin
                    total_reg <= total_reg + 64'd1;
                end
                if (cmd.add_en)
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        hash_reg[j] <= hash_reg[j] + work_reg[j];
                    end
                end
            end

            if (cmd.comp_start)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_en)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

    assign status.fill       = fill_reg;
    assign status.round_last = (round_reg == 6'd63);
    assign digest_word       = hash_reg[cmd.out_idx];

endmodule

/* hdl/sha_ctrl.sv */
// sha256 controller: item intake, padding sequence, compression and digest output
`timescale 1ns / 1ps

module sha_ctrl
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_count,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_index,
    output logic       out_last,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUT   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // padding progress of the final item
    localparam logic [1:0] ST_MARK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] left_reg;
    logic [2:0] left_next;
    logic       last_reg;
    logic       last_next;
    logic [1:0] stage_reg;
    logic [1:0] stage_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] count_sat;
    logic       more_put;
    logic       more_now;

    assign count_sat = (in_count > MAX_BYTES) ? MAX_BYTES : in_count;
    assign more_now  = (left_reg != 3'd0) || (last_reg && stage_reg != ST_OUT);

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        stage_next     = stage_reg;
        idx_next       = idx_reg;
        more_put       = 1'b0;
        cmd            = '0;
        cmd.byte_src   = SRC_DATA;
        cmd.out_idx    = idx_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    left_next  = count_sat;
                    last_next  = in_last;
                    stage_next = ST_MARK;
                    if (count_sat != 3'd0 || in_last)
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
                if (left_reg != 3'd0)
                begin
                    cmd.byte_src = SRC_DATA;
                    left_next    = left_reg - 3'd1;
                end
                else
                begin
                    unique case (stage_reg)
                        ST_MARK:
                        begin
                            cmd.byte_src = SRC_MARK;
                            stage_next   = ST_ZERO;
                        end
                        ST_ZERO:
                        begin
                            if (status.fill == LEN_POS)
                            begin
                                cmd.byte_src = SRC_LEN;
                                stage_next   = ST_LEN;
                            end
                            else
                            begin
                                cmd.byte_src = SRC_ZERO;
                            end
                        end
                        ST_LEN:
                        begin
                            cmd.byte_src = SRC_LEN;
                            if (status.fill == FILL_TOP)
                            begin
                                stage_next = ST_OUT;
                            end
                        end
                        default:
                        begin
                            cmd.put = 1'b0;
                        end
                    endcase
                end
                // bytes still to write after this one
                more_put = (left_next != 3'd0) || (last_reg && stage_next != ST_OUT);
                // a full block starts the compression
                if (status.fill == FILL_TOP)
                begin
                    cmd.comp_start = 1'b1;
                    state_next     = S_ROUND;
                end
                else if (!more_put)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round_last)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_en = 1'b1;
                if (more_now)
                begin
                    state_next = S_PUT;
                end
                else if (last_reg && stage_reg == ST_OUT)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        cmd.restart = 1'b1;
                        idx_next    = 3'd0;
                        last_next   = 1'b0;
                        stage_next  = ST_MARK;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            left_reg  <= '0;
            last_reg  <= 1'b0;
            stage_reg <= ST_MARK;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_index = idx_reg;
    assign out_last  = (idx_reg == LAST_IDX);

endmodule
